// ----- hw/rtl/pspu_pkg.sv -----
// Shared constants of the point-to-segment projection unit.
// Register index codes for the configuration port; no dependencies.
package pspu_pkg;

  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] REG_START_X = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_START_Y = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_END_X   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_END_Y   = 2'd3;

endpackage

// ----- hw/rtl/point_to_segment_projection_unit.sv -----
// Top level of the point-to-segment projection unit: segment registers,
// stall control and the pipeline. Uses pspu_pkg and all pspu_* modules.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, query_x/y_i       | into block
//   out     | out_valid_o, out_ready_i, on_edge_o,      | out of block
//           | foot_x/y_o, dist_res_o                    |
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | into block
//           | cfg_data_i                                |
//
// One beat enters per cycle unless the pipeline stalls; the divider and the
// square root each resolve one bit per stage. All stages advance together
// whenever the output stage is empty or taken, so a stall holds every beat.
// Reset clears the valid bits and the segment registers; no clearing pass.
module point_to_segment_projection_unit #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       query_x_i,
  input  logic signed [COORD_WIDTH-1:0]       query_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                on_edge_o,
  output logic signed [COORD_WIDTH-1:0]       foot_x_o,
  output logic signed [COORD_WIDTH-1:0]       foot_y_o,
  output logic [COORD_WIDTH:0]                dist_res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pspu_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]              cfg_data_i
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;

  logic signed [W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pspu_pkg::REG_START_X: start_x_q <= cfg_data_i;
        pspu_pkg::REG_START_Y: start_y_q <= cfg_data_i;
        pspu_pkg::REG_END_X:   end_x_q   <= cfg_data_i;
        pspu_pkg::REG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic                v1, on1, v2, on2, v3, on3, v4, on4;
  logic [3*DW-1:0]     nx1, ny1;
  logic [2*DW-1:0]     len1, d2;
  logic signed [W-1:0] qx1, qy1, qx2, qy2, fx3, fy3, fx4, fy4;
  logic [DW-1:0]       offx, offy, root;

  pspu_front #(.W(W)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .query_x_i, .query_y_i,
    .start_x_i(start_x_q), .start_y_i(start_y_q), .end_x_i(end_x_q), .end_y_i(end_y_q),
    .valid_o(v1), .on_o(on1), .num_x_o(nx1), .num_y_o(ny1), .len_o(len1),
    .qx_o(qx1), .qy_o(qy1)
  );

  pspu_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .on_i(on1),
    .num_x_i(nx1), .num_y_i(ny1), .len_i(len1), .qx_i(qx1), .qy_i(qy1),
    .valid_o(v2), .on_o(on2), .off_x_o(offx), .off_y_o(offy), .qx_o(qx2), .qy_o(qy2)
  );

  pspu_dist #(.W(W)) u_dist (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .on_i(on2),
    .off_x_i(offx), .off_y_i(offy), .qx_i(qx2), .qy_i(qy2),
    .start_x_i(start_x_q), .start_y_i(start_y_q), .end_x_i(end_x_q), .end_y_i(end_y_q),
    .valid_o(v3), .on_o(on3), .foot_x_o(fx3), .foot_y_o(fy3), .d2_o(d2)
  );

  pspu_sqrt #(.W(W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3), .on_i(on3),
    .foot_x_i(fx3), .foot_y_i(fy3), .d2_i(d2),
    .valid_o(v4), .on_o(on4), .foot_x_o(fx4), .foot_y_o(fy4), .root_o(root)
  );

  assign out_valid_o = v4;
  assign on_edge_o   = on4;
  assign foot_x_o    = on4 ? fx4 : '0;
  assign foot_y_o    = on4 ? fy4 : '0;
  assign dist_res_o  = on4 ? root : '0;

endmodule

// ----- hw/rtl/pspu_front.sv -----
// Front pipeline: offsets, dot product, squared length, range test and
// the wide numerators for the divider. Six register stages; no package use.
module pspu_front #(
  parameter int unsigned W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [W-1:0]    query_x_i,
  input  logic signed [W-1:0]    query_y_i,
  input  logic signed [W-1:0]    start_x_i,
  input  logic signed [W-1:0]    start_y_i,
  input  logic signed [W-1:0]    end_x_i,
  input  logic signed [W-1:0]    end_y_i,
  output logic                   valid_o,
  output logic                   on_o,
  output logic [3*(W+1)-1:0]     num_x_o,
  output logic [3*(W+1)-1:0]     num_y_o,
  output logic [2*(W+1)-1:0]     len_o,
  output logic signed [W-1:0]    qx_o,
  output logic signed [W-1:0]    qy_o
);

  localparam int unsigned DW   = W + 1;
  localparam int unsigned LENW = 2 * DW;
  localparam int unsigned DOTW = 2 * DW + 1;
  localparam int unsigned NW   = 3 * DW;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;

  assign dx  = $signed({end_x_i[W-1], end_x_i}) - $signed({start_x_i[W-1], start_x_i});
  assign dy  = $signed({end_y_i[W-1], end_y_i}) - $signed({start_y_i[W-1], start_y_i});
  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

  logic [5:0] v_q;
  logic signed [W-1:0] qx_q [6];
  logic signed [W-1:0] qy_q [6];

  logic signed [DW-1:0]   ox_q, oy_q;
  logic signed [LENW-1:0] px_q, py_q;
  logic [LENW-1:0]        lx_q, ly_q;
  logic signed [DOTW-1:0] dot_q;
  logic [LENW-1:0]        len3_q, len4_q, len5_q, len6_q;
  logic [LENW-1:0]        dotu_q;
  logic                   on4_q, on5_q, on6_q;
  logic [LENW-1:0]        plx_q, phx_q, ply_q, phy_q;
  logic [NW-1:0]          numx_q, numy_q;
  logic                   on_d;

  assign on_d = (len3_q != '0) && !dot_q[DOTW-1] && (dot_q <= $signed({1'b0, len3_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q[0] <= query_x_i;
      qy_q[0] <= query_y_i;
      for (int k = 1; k < 6; k++) begin
        qx_q[k] <= qx_q[k-1];
        qy_q[k] <= qy_q[k-1];
      end
      ox_q   <= $signed({query_x_i[W-1], query_x_i}) - $signed({start_x_i[W-1], start_x_i});
      oy_q   <= $signed({query_y_i[W-1], query_y_i}) - $signed({start_y_i[W-1], start_y_i});
      px_q   <= dx * ox_q;
      py_q   <= dy * oy_q;
      lx_q   <= adx * adx;
      ly_q   <= ady * ady;
      dot_q  <= DOTW'(px_q) + DOTW'(py_q);
      len3_q <= lx_q + ly_q;
      on4_q  <= on_d;
      dotu_q <= dot_q[LENW-1:0];
      len4_q <= len3_q;
      plx_q  <= dotu_q[DW-1:0] * adx;
      phx_q  <= dotu_q[LENW-1:DW] * adx;
      ply_q  <= dotu_q[DW-1:0] * ady;
      phy_q  <= dotu_q[LENW-1:DW] * ady;
      on5_q  <= on4_q;
      len5_q <= len4_q;
      numx_q <= {phx_q, {DW{1'b0}}} + NW'(plx_q);
      numy_q <= {phy_q, {DW{1'b0}}} + NW'(ply_q);
      on6_q  <= on5_q;
      len6_q <= len5_q;
    end
  end

  assign valid_o = v_q[5];
  assign on_o    = on6_q;
  assign num_x_o = numx_q;
  assign num_y_o = numy_q;
  assign len_o   = len6_q;
  assign qx_o    = qx_q[5];
  assign qy_o    = qy_q[5];

endmodule

// ----- hw/rtl/pspu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share the divisor. Depends on nothing outside this file.
module pspu_div #(
  parameter int unsigned W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic                   on_i,
  input  logic [3*(W+1)-1:0]     num_x_i,
  input  logic [3*(W+1)-1:0]     num_y_i,
  input  logic [2*(W+1)-1:0]     len_i,
  input  logic signed [W-1:0]    qx_i,
  input  logic signed [W-1:0]    qy_i,
  output logic                   valid_o,
  output logic                   on_o,
  output logic [W:0]             off_x_o,
  output logic [W:0]             off_y_o,
  output logic signed [W-1:0]    qx_o,
  output logic signed [W-1:0]    qy_o
);

  localparam int unsigned QW   = W + 1;
  localparam int unsigned LENW = 2 * QW;
  localparam int unsigned NW   = 3 * QW;

  logic                v_q   [QW];
  logic                on_q  [QW];
  logic [NW-1:0]       rx_q  [QW];
  logic [NW-1:0]       ry_q  [QW];
  logic [QW-1:0]       ox_q  [QW];
  logic [QW-1:0]       oy_q  [QW];
  logic [LENW-1:0]     len_q [QW];
  logic signed [W-1:0] qx_q  [QW];
  logic signed [W-1:0] qy_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic                v_c, on_c;
    logic [NW-1:0]       rx_c, ry_c, t_c;
    logic [QW-1:0]       ox_c, oy_c;
    logic [LENW-1:0]     len_c;
    logic signed [W-1:0] qx_c, qy_c;
    logic                gx, gy;

    if (k == 0) begin : g_in
      assign v_c   = valid_i;
      assign on_c  = on_i;
      assign rx_c  = num_x_i;
      assign ry_c  = num_y_i;
      assign ox_c  = '0;
      assign oy_c  = '0;
      assign len_c = len_i;
      assign qx_c  = qx_i;
      assign qy_c  = qy_i;
    end else begin : g_prev
      assign v_c   = v_q[k-1];
      assign on_c  = on_q[k-1];
      assign rx_c  = rx_q[k-1];
      assign ry_c  = ry_q[k-1];
      assign ox_c  = ox_q[k-1];
      assign oy_c  = oy_q[k-1];
      assign len_c = len_q[k-1];
      assign qx_c  = qx_q[k-1];
      assign qy_c  = qy_q[k-1];
    end

    assign t_c = NW'(len_c) << B;
    assign gx  = rx_c >= t_c;
    assign gy  = ry_c >= t_c;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        on_q[k]  <= on_c;
        rx_q[k]  <= gx ? rx_c - t_c : rx_c;
        ry_q[k]  <= gy ? ry_c - t_c : ry_c;
        ox_q[k]  <= ox_c | (QW'(gx) << B);
        oy_q[k]  <= oy_c | (QW'(gy) << B);
        len_q[k] <= len_c;
        qx_q[k]  <= qx_c;
        qy_q[k]  <= qy_c;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign on_o    = on_q[QW-1];
  assign off_x_o = ox_q[QW-1];
  assign off_y_o = oy_q[QW-1];
  assign qx_o    = qx_q[QW-1];
  assign qy_o    = qy_q[QW-1];

endmodule

// ----- hw/rtl/pspu_dist.sv -----
// Foot point, residual vector and squared distance in four register stages.
// Depends on nothing outside this file.
module pspu_dist #(
  parameter int unsigned W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic                   on_i,
  input  logic [W:0]             off_x_i,
  input  logic [W:0]             off_y_i,
  input  logic signed [W-1:0]    qx_i,
  input  logic signed [W-1:0]    qy_i,
  input  logic signed [W-1:0]    start_x_i,
  input  logic signed [W-1:0]    start_y_i,
  input  logic signed [W-1:0]    end_x_i,
  input  logic signed [W-1:0]    end_y_i,
  output logic                   valid_o,
  output logic                   on_o,
  output logic signed [W-1:0]    foot_x_o,
  output logic signed [W-1:0]    foot_y_o,
  output logic [2*(W+1)-1:0]     d2_o
);

  localparam int unsigned DW   = W + 1;
  localparam int unsigned LENW = 2 * DW;

  logic neg_x, neg_y;
  assign neg_x = end_x_i < start_x_i;
  assign neg_y = end_y_i < start_y_i;

  logic [3:0]           v_q;
  logic                 on_q [4];
  logic signed [W-1:0]  fx_q [4];
  logic signed [W-1:0]  fy_q [4];
  logic signed [W-1:0]  qx1_q, qy1_q;
  logic signed [DW-1:0] rx, ry;
  logic [DW-1:0]        arx_q, ary_q;
  logic [LENW-1:0]      sx_q, sy_q, d2_q;

  assign rx = $signed({qx1_q[W-1], qx1_q}) - $signed({fx_q[0][W-1], fx_q[0]});
  assign ry = $signed({qy1_q[W-1], qy1_q}) - $signed({fy_q[0][W-1], fy_q[0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      on_q[0] <= on_i;
      fx_q[0] <= neg_x ? start_x_i - W'(off_x_i) : start_x_i + W'(off_x_i);
      fy_q[0] <= neg_y ? start_y_i - W'(off_y_i) : start_y_i + W'(off_y_i);
      qx1_q   <= qx_i;
      qy1_q   <= qy_i;
      for (int k = 1; k < 4; k++) begin
        on_q[k] <= on_q[k-1];
        fx_q[k] <= fx_q[k-1];
        fy_q[k] <= fy_q[k-1];
      end
      arx_q <= rx[DW-1] ? DW'(-rx) : DW'(rx);
      ary_q <= ry[DW-1] ? DW'(-ry) : DW'(ry);
      sx_q  <= arx_q * arx_q;
      sy_q  <= ary_q * ary_q;
      d2_q  <= sx_q + sy_q;
    end
  end

  assign valid_o  = v_q[3];
  assign on_o     = on_q[3];
  assign foot_x_o = fx_q[3];
  assign foot_y_o = fy_q[3];
  assign d2_o     = d2_q;

endmodule

// ----- hw/rtl/pspu_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, carrying the
// foot point alongside. Depends on nothing outside this file.
module pspu_sqrt #(
  parameter int unsigned W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic                   on_i,
  input  logic signed [W-1:0]    foot_x_i,
  input  logic signed [W-1:0]    foot_y_i,
  input  logic [2*(W+1)-1:0]     d2_i,
  output logic                   valid_o,
  output logic                   on_o,
  output logic signed [W-1:0]    foot_x_o,
  output logic signed [W-1:0]    foot_y_o,
  output logic [W:0]             root_o
);

  localparam int unsigned SW = W + 1;
  localparam int unsigned XW = 2 * SW;

  logic                v_q  [SW];
  logic                on_q [SW];
  logic [XW-1:0]       x_q  [SW];
  logic [SW-1:0]       r_q  [SW];
  logic signed [W-1:0] fx_q [SW];
  logic signed [W-1:0] fy_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int unsigned B = SW - 1 - k;
    logic                v_c, on_c, g;
    logic [XW-1:0]       x_c, t_c;
    logic [SW-1:0]       r_c;
    logic signed [W-1:0] fx_c, fy_c;

    if (k == 0) begin : g_in
      assign v_c  = valid_i;
      assign on_c = on_i;
      assign x_c  = d2_i;
      assign r_c  = '0;
      assign fx_c = foot_x_i;
      assign fy_c = foot_y_i;
    end else begin : g_prev
      assign v_c  = v_q[k-1];
      assign on_c = on_q[k-1];
      assign x_c  = x_q[k-1];
      assign r_c  = r_q[k-1];
      assign fx_c = fx_q[k-1];
      assign fy_c = fy_q[k-1];
    end

    assign t_c = (XW'(r_c) << (B + 1)) | (XW'(1) << (2 * B));
    assign g   = x_c >= t_c;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        on_q[k] <= on_c;
        x_q[k]  <= g ? x_c - t_c : x_c;
        r_q[k]  <= r_c | (SW'(g) << B);
        fx_q[k] <= fx_c;
        fy_q[k] <= fy_c;
      end
    end
  end

  assign valid_o  = v_q[SW-1];
  assign on_o     = on_q[SW-1];
  assign foot_x_o = fx_q[SW-1];
  assign foot_y_o = fy_q[SW-1];
  assign root_o   = r_q[SW-1];

endmodule
